// File: src/scl_pkg.sv
// scl_pkg: shared types and constants for the sequence code lock.
// Holds the controller state enum, the command/status structs between
// the controller and the datapath, generator constants and reset values.
package scl_pkg;

    // input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    // configuration register indexes
    localparam logic REG_DEBOUNCE = 1'b0;
    localparam logic REG_SHOW     = 1'b1;

    // register reset values
    localparam logic [9:0]  DEBOUNCE_RST = 10'd50;
    localparam logic [15:0] SHOW_RST     = 16'd1000;

    // LCG multiplier and increment, only the low 31 bits matter
    localparam logic [30:0] LCG_MUL = 31'h41C6_4E6D;
    localparam logic [30:0] LCG_INC = 31'd12345;

    localparam logic [3:0] LAMPS_ALL = 4'hF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_BTN_RD,
        S_BTN_EV,
        S_SHOW_RD,
        S_SHOW_EV,
        S_DONE
    } scl_state_t;

    typedef struct packed {
        logic arm_start;
        logic tick_start;
        logic draw;
        logic rd_entry;
        logic rd_show;
        logic btn_eval;
        logic show_eval;
        logic load_out;
    } scl_cmd_t;

    typedef struct packed {
        logic active;
        logic arm_done;
        logic btn_last;
        logic out_free;
    } scl_status_t;

endpackage

// File: src/scl_ctrl.sv
// scl_ctrl: sequencing state machine for the sequence code lock.
// Depends on scl_pkg (state enum, command and status structs).
module scl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 command,
    input  scl_pkg::scl_status_t status,
    output logic                 item_stall,
    output scl_pkg::scl_cmd_t    cmd
);
    import scl_pkg::*;

    scl_state_t state_reg;
    scl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (command == CMD_ARM)
                    begin
                        state_next = S_ARM;
                    end
                    else if (status.active)
                    begin
                        state_next = S_BTN_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ARM:
            begin
                if (status.arm_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_BTN_RD:  state_next = S_BTN_EV;
            S_BTN_EV:  state_next = status.btn_last ? S_SHOW_RD : S_BTN_RD;
            S_SHOW_RD: state_next = S_SHOW_EV;
            S_SHOW_EV: state_next = S_DONE;
            S_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                item_stall     = 1'b0;
                cmd.arm_start  = item_valid && (command == CMD_ARM);
                cmd.tick_start = item_valid && (command == CMD_TICK);
            end
            S_ARM:     cmd.draw      = 1'b1;
            S_BTN_RD:  cmd.rd_entry  = 1'b1;
            S_BTN_EV:  cmd.btn_eval  = 1'b1;
            S_SHOW_RD: cmd.rd_show   = 1'b1;
            S_SHOW_EV: cmd.show_eval = 1'b1;
            S_DONE:    cmd.load_out  = status.out_free;
            default:   cmd           = '0;
        endcase
    end

endmodule

// File: src/scl_dp.sv
// scl_dp: datapath of the sequence code lock: code memory, generator,
// debounce timers, entry and playback state, config and result registers.
// Depends on scl_pkg (command/status structs, constants).
module scl_dp #(
    parameter int CODE_LENGTH = 8,
    parameter int MAX_REDRAWS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scl_pkg::scl_cmd_t    cmd,
    output scl_pkg::scl_status_t status,
    input  logic [3:0]           buttons,
    input  logic [15:0]          seed,
    input  logic                 cfg_write,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 result_stall,
    output logic                 result_valid,
    output logic [3:0]           lamps,
    output logic [3:0]           progress,
    output logic                 wrong_press,
    output logic                 solved,
    output logic                 armed
);
    import scl_pkg::*;

    localparam int AW = $clog2(CODE_LENGTH);
    localparam int EW = $clog2(CODE_LENGTH + 1);
    localparam int RW = $clog2(MAX_REDRAWS + 1);
    localparam logic [EW-1:0] CODE_END  = EW'(CODE_LENGTH);
    localparam logic [AW-1:0] LAST_STEP = AW'(CODE_LENGTH - 1);
    localparam logic [RW-1:0] REDRAW_CAP = RW'(MAX_REDRAWS);
    localparam logic [3:0]    CL_LOW = 4'(CODE_LENGTH);

    // config
    logic [9:0]  debounce_reg;
    logic [15:0] show_ms_reg;

    // code memory, one read port with registered data
    logic [1:0]    code_mem [CODE_LENGTH];
    logic [1:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;

    // generator and arm sequencing
    logic [15:0]   rng_reg;
    logic [1:0]    prev_reg;
    logic [AW-1:0] arm_idx_reg;
    logic [RW-1:0] red_cnt_reg;
    logic [30:0]   lcg_sum;
    logic [1:0]    draw_val;
    logic          draw_keep;

    // tick state
    logic [31:0]   ms_count_reg;
    logic [3:0]    buttons_reg;
    logic [1:0]    btn_idx_reg;
    logic [3:0]    held_reg;
    logic [31:0]   last_reg [4];
    logic [EW-1:0] entry_reg;
    logic [EW-1:0] show_idx_reg;
    logic          show_lit_reg;
    logic [31:0]   show_start_reg;
    logic [3:0]    lamp_reg;
    logic          active_reg;
    logic          wrong_reg;
    logic          solved_reg;

    logic [31:0]   since_last;
    logic [31:0]   since_show;
    logic          pressed;
    logic          press_ok;
    logic          entry_full;
    logic          show_steps;
    logic [3:0]    code_lamp;
    logic [EW+3:0] entry_ext;

    // result register
    logic          result_valid_reg;
    logic [3:0]    lamps_reg;
    logic [3:0]    progress_reg;
    logic          wrong_out_reg;
    logic          solved_out_reg;
    logic          armed_reg;

    // one LCG step: keep bits 30..16 of s*mul+inc
    assign lcg_sum   = 31'({15'b0, rng_reg} * LCG_MUL + LCG_INC);
    assign draw_val  = lcg_sum[17:16];
    assign draw_keep = (arm_idx_reg == '0) || (draw_val != prev_reg)
                       || (red_cnt_reg == REDRAW_CAP);

    assign rd_addr = cmd.rd_show ? show_idx_reg[AW-1:0] : entry_reg[AW-1:0];

    assign pressed    = ~buttons_reg[btn_idx_reg];
    assign since_last = ms_count_reg - last_reg[btn_idx_reg];
    assign press_ok   = pressed && !held_reg[btn_idx_reg]
                        && (since_last >= {22'b0, debounce_reg});
    assign entry_full = entry_reg >= CODE_END;
    assign show_steps = show_idx_reg < CODE_END;
    assign since_show = ms_count_reg - show_start_reg;
    assign code_lamp  = 4'(4'b0001 << rd_data_reg);
    assign entry_ext  = {4'b0, entry_reg};

    // arm_done is only looked at while drawing
    assign status.active   = active_reg;
    assign status.arm_done = draw_keep && (arm_idx_reg == LAST_STEP);
    assign status.btn_last = (btn_idx_reg == 2'd3);
    assign status.out_free = !result_valid_reg || !result_stall;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            show_ms_reg  <= SHOW_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_DEBOUNCE)
            begin
                debounce_reg <= cfg_data[9:0];
            end
            else
            begin
                show_ms_reg <= cfg_data;
            end
        end
    end

    // code memory
    always_ff @(posedge clk)
    begin
        if (cmd.draw && draw_keep)
        begin
            code_mem[arm_idx_reg] <= draw_val;
        end
        if (cmd.rd_entry || cmd.rd_show)
        begin
            rd_data_reg <= code_mem[rd_addr];
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.arm_start)
        begin
            rng_reg     <= seed;
            arm_idx_reg <= '0;
            red_cnt_reg <= '0;
        end
        else if (cmd.draw)
        begin
            rng_reg <= {1'b0, lcg_sum[30:16]};
            if (draw_keep)
            begin
                prev_reg    <= draw_val;
                arm_idx_reg <= arm_idx_reg + AW'(1);
                red_cnt_reg <= '0;
            end
            else
            begin
                red_cnt_reg <= red_cnt_reg + RW'(1);
            end
        end
        if (cmd.tick_start)
        begin
            buttons_reg <= buttons;
            btn_idx_reg <= '0;
        end
        else if (cmd.btn_eval)
        begin
            btn_idx_reg <= btn_idx_reg + 2'd1;
        end
        if (cmd.load_out)
        begin
            lamps_reg      <= lamp_reg;
            progress_reg   <= solved_reg ? CL_LOW : entry_ext[3:0];
            wrong_out_reg  <= wrong_reg;
            solved_out_reg <= solved_reg;
            armed_reg      <= active_reg;
        end
    end

    // lock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_count_reg   <= '0;
            held_reg       <= '0;
            last_reg       <= '{default: '0};
            entry_reg      <= '0;
            show_idx_reg   <= '0;
            show_lit_reg   <= 1'b0;
            show_start_reg <= '0;
            lamp_reg       <= '0;
            active_reg     <= 1'b0;
            wrong_reg      <= 1'b0;
            solved_reg     <= 1'b0;
        end
        else if (cmd.arm_start)
        begin
            active_reg   <= 1'b1;
            entry_reg    <= '0;
            show_idx_reg <= '0;
            show_lit_reg <= 1'b0;
            lamp_reg     <= '0;
            wrong_reg    <= 1'b0;
            solved_reg   <= 1'b0;
        end
        else if (cmd.tick_start)
        begin
            ms_count_reg <= ms_count_reg + 32'd1;
            wrong_reg    <= 1'b0;
            solved_reg   <= 1'b0;
        end
        else if (cmd.btn_eval)
        begin
            if (!pressed)
            begin
                held_reg[btn_idx_reg] <= 1'b0;
            end
            else if (press_ok)
            begin
                held_reg[btn_idx_reg] <= 1'b1;
                last_reg[btn_idx_reg] <= ms_count_reg;
                if (!entry_full)
                begin
                    if (rd_data_reg == btn_idx_reg)
                    begin
                        entry_reg <= entry_reg + EW'(1);
                    end
                    else
                    begin
                        entry_reg <= '0;
                        wrong_reg <= 1'b1;
                    end
                end
            end
        end
        else if (cmd.show_eval)
        begin
            if (entry_full)
            begin
                solved_reg   <= 1'b1;
                lamp_reg     <= '0;
                active_reg   <= 1'b0;
                entry_reg    <= '0;
                show_idx_reg <= '0;
                show_lit_reg <= 1'b0;
            end
            else if (!show_lit_reg)
            begin
                lamp_reg       <= show_steps ? (lamp_reg | code_lamp) : LAMPS_ALL;
                show_start_reg <= ms_count_reg;
                show_lit_reg   <= 1'b1;
            end
            else if (since_show >= {16'b0, show_ms_reg})
            begin
                if (show_steps)
                begin
                    lamp_reg     <= lamp_reg & ~code_lamp;
                    show_idx_reg <= show_idx_reg + EW'(1);
                end
                else
                begin
                    lamp_reg     <= '0;
                    show_idx_reg <= '0;
                end
                show_lit_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign lamps        = lamps_reg;
    assign progress     = progress_reg;
    assign wrong_press  = wrong_out_reg;
    assign solved       = solved_out_reg;
    assign armed        = armed_reg;

endmodule

// File: src/sequence_code_lock.sv
// sequence_code_lock: top level of the button sequence code lock.
// Instantiates scl_ctrl (sequencer) and scl_dp (datapath); uses scl_pkg.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  item    | in        | item_valid / item_stall    | command, buttons, seed
//  result  | out       | result_valid / result_stall| lamps, progress, wrong_press,
//          |           |                            |   solved, armed
//  config  | in        | cfg_write (no wait)        | cfg_index, cfg_data
//
// Sequence: a tick while armed is accepted, then for each of the four buttons
//   reads the code memory and checks the press, then reads and evaluates
//   playback, then posts the result; a tick while disarmed is accepted and
//   then posts its result. An arm makes one generator draw per step plus one
//   per redraw, at most CODE_LENGTH + (CODE_LENGTH - 1) * MAX_REDRAWS draws
//   since the first step never redraws. The single code memory read port and
//   the one LCG step per cycle set this pace.
// Reset: rst_n clears all lock state and restores debounce_ms = 50 and
//   show_ms = 1000; the code memory needs no clearing pass.
// Stalls: the result register holds a finished request while result_stall is
//   high; the next request is still taken and waits only to post its result.
module sequence_code_lock #(
    parameter int CODE_LENGTH = 8,
    parameter int MAX_REDRAWS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        command,
    input  logic [3:0]  buttons,
    input  logic [15:0] seed,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  lamps,
    output logic [3:0]  progress,
    output logic        wrong_press,
    output logic        solved,
    output logic        armed,
    // config port
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import scl_pkg::*;

    scl_cmd_t    cmd;
    scl_status_t status;

    // Sequencer: picks arm (generator draws) or tick from the accepted request; an armed
    // tick walks the four buttons, then playback; each then posts the result when the slot is free.
    scl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (command),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // Datapath: generator, code memory, debounce, entry progress, playback
    // timer and the result register.
    scl_dp #(
        .CODE_LENGTH (CODE_LENGTH),
        .MAX_REDRAWS (MAX_REDRAWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .buttons      (buttons),
        .seed         (seed),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .lamps        (lamps),
        .progress     (progress),
        .wrong_press  (wrong_press),
        .solved       (solved),
        .armed        (armed)
    );

    // a taken request closes the input side in the cycle after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken again right after a request");

    // the result is posted only into a free slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result posted over a pending result");

    // solving disarms and darkens the lamps
    a_solve_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && solved |-> !armed && lamps == 4'b0)
        else $error("solve left lock armed or lamps lit");

    // a disarmed lock without a solve shows nothing
    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !armed && !solved |-> lamps == 4'b0 && progress == 4'b0)
        else $error("disarmed lock shows lamps or progress");

endmodule
